FILE: rtl/cau_pkg.sv
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OP_W           = 3;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_MOD = 3'd4;

  // per-request control that rides along the pipeline
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic            neg_re;
    logic            neg_im;
    logic            dz;
  } ctrl_t;

endpackage

FILE: rtl/cau_step.sv
module cau_step
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int K          = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  ctrl_t                     ctrl_in,
  input  logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_re_in,
  input  logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_im_in,
  input  logic [DATA_WIDTH:0]       q_re_in,
  input  logic [DATA_WIDTH:0]       q_im_in,
  input  logic [2*DATA_WIDTH-1:0]   d_in,
  input  logic [2*DATA_WIDTH:0]     sq_rem_in,
  input  logic [DATA_WIDTH-1:0]     sq_root_in,
  input  logic [DATA_WIDTH-1:0]     res_re_in,
  input  logic [DATA_WIDTH-1:0]     res_im_in,
  input  logic                      sat_in,
  output ctrl_t                     ctrl_out,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_re_out,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_im_out,
  output logic [DATA_WIDTH:0]       q_re_out,
  output logic [DATA_WIDTH:0]       q_im_out,
  output logic [2*DATA_WIDTH-1:0]   d_out,
  output logic [2*DATA_WIDTH:0]     sq_rem_out,
  output logic [DATA_WIDTH-1:0]     sq_root_out,
  output logic [DATA_WIDTH-1:0]     res_re_out,
  output logic [DATA_WIDTH-1:0]     res_im_out,
  output logic                      sat_out
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = 3*DATA_WIDTH+FRAC_BITS;
  localparam int SW = 2*DATA_WIDTH+1;

  logic [RW-1:0]  dsh;
  logic [RW-1:0]  rem_re_next, rem_im_next;
  logic [W:0]     q_re_next, q_im_next;
  logic [SW-1:0]  sq_rem_next;
  logic [W-1:0]   sq_root_next;

  // one quotient bit for each part
  always_comb begin
    dsh         = RW'(d_in) << K;
    rem_re_next = rem_re_in;
    rem_im_next = rem_im_in;
    q_re_next   = q_re_in;
    q_im_next   = q_im_in;
    if (rem_re_in >= dsh) begin
      rem_re_next  = rem_re_in - dsh;
      q_re_next[K] = 1'b1;
    end
    if (rem_im_in >= dsh) begin
      rem_im_next  = rem_im_in - dsh;
      q_im_next[K] = 1'b1;
    end
  end

  // one root bit, the top step has none
  generate
    if (K < W) begin : g_root
      logic [SW-1:0] trial;
      always_comb begin
        trial        = (SW'(sq_root_in) << (K + 1)) + (SW'(1) << (2 * K));
        sq_rem_next  = sq_rem_in;
        sq_root_next = sq_root_in;
        if (sq_rem_in >= trial) begin
          sq_rem_next     = sq_rem_in - trial;
          sq_root_next[K] = 1'b1;
        end
      end
    end else begin : g_noroot
      assign sq_rem_next  = sq_rem_in;
      assign sq_root_next = sq_root_in;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re_out  <= rem_re_next;
      rem_im_out  <= rem_im_next;
      q_re_out    <= q_re_next;
      q_im_out    <= q_im_next;
      d_out       <= d_in;
      sq_rem_out  <= sq_rem_next;
      sq_root_out <= sq_root_next;
      res_re_out  <= res_re_in;
      res_im_out  <= res_im_in;
      sat_out     <= sat_in;
    end
  end

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// complex alu on signed fixed point, one request accepted per cycle while the pipe advances
// a request passes stage 1, stage 2, the divide steps and the output register
// throughput: one request per cycle; the whole pipe advances when the output
// register is empty or being taken, and holds as one while it is stalled
// the divider resolves one bit per stage over DATA_WIDTH + 1 stages, the root over DATA_WIDTH
// reset (synchronous, active high) clears every stage valid; data registers keep their value
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [OP_W-1:0]              operation,
  input  logic signed [DATA_WIDTH-1:0] a_real,
  input  logic signed [DATA_WIDTH-1:0] a_imag,
  input  logic signed [DATA_WIDTH-1:0] b_real,
  input  logic signed [DATA_WIDTH-1:0] b_imag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] result_real,
  output logic signed [DATA_WIDTH-1:0] result_imag,
  output logic                         divide_by_zero,
  output logic                         saturated
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2*DATA_WIDTH;
  localparam int RW = 3*DATA_WIDTH+FRAC_BITS;
  localparam int SW = 2*DATA_WIDTH+1;
  localparam int NS = DATA_WIDTH+1;

  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  // global advance: the output register is free or drained this cycle
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------
  // stage 1: six products, add and subtract finished here
  // ---------------------------------------------------------------
  logic signed [W:0] as_re, as_im;
  logic [W-1:0]      simp_re, simp_im;
  logic              simp_sat;
  logic signed [W-1:0] m4a, m4b, m5a, m5b;

  always_comb begin
    if (operation == OP_SUB) begin
      as_re = (W+1)'(a_real) - (W+1)'(b_real);
      as_im = (W+1)'(a_imag) - (W+1)'(b_imag);
    end else begin
      as_re = (W+1)'(a_real) + (W+1)'(b_real);
      as_im = (W+1)'(a_imag) + (W+1)'(b_imag);
    end
    // an overflow shows as the two top bits differing
    simp_re  = (as_re[W] != as_re[W-1]) ? (as_re[W] ? SMIN : SMAX) : as_re[W-1:0];
    simp_im  = (as_im[W] != as_im[W-1]) ? (as_im[W] ? SMIN : SMAX) : as_im[W-1:0];
    simp_sat = (as_re[W] != as_re[W-1]) || (as_im[W] != as_im[W-1]);
    // the spare pair of multipliers squares a for modulus, b for divide
    if (operation == OP_MOD) begin
      m4a = a_real; m4b = a_real; m5a = a_imag; m5b = a_imag;
    end else begin
      m4a = b_real; m4b = b_real; m5a = b_imag; m5b = b_imag;
    end
  end

  logic              v1;
  logic [OP_W-1:0]   op1;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic [W-1:0]      s1_re, s1_im;
  logic              s1_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= operation;
      p0     <= PW'(a_real) * PW'(b_real);
      p1     <= PW'(a_imag) * PW'(b_imag);
      p2     <= PW'(a_real) * PW'(b_imag);
      p3     <= PW'(a_imag) * PW'(b_real);
      p4     <= PW'(m4a) * PW'(m4b);
      p5     <= PW'(m5a) * PW'(m5b);
      s1_re  <= simp_re;
      s1_im  <= simp_im;
      s1_sat <= simp_sat;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: sums of products; multiply finished, divider and root loaded
  // ---------------------------------------------------------------
  logic signed [SW-1:0] mul_re, mul_im, div_re, div_im, dsum, sh_re, sh_im;
  logic [PW-1:0]        mag_re, mag_im, dval;
  logic [W-1:0]         mr_re, mr_im;
  logic                 ovf_mre, ovf_mim;
  ctrl_t                c2;
  logic [W-1:0]         r2_re, r2_im;
  logic                 r2_sat;

  always_comb begin
    mul_re = SW'(p0) - SW'(p1);
    mul_im = SW'(p2) + SW'(p3);
    div_re = SW'(p0) + SW'(p1);
    div_im = SW'(p3) - SW'(p2);
    dsum   = SW'(p4) + SW'(p5);
    dval   = dsum[PW-1:0];
    // arithmetic shift gives the floor
    sh_re  = mul_re >>> F;
    sh_im  = mul_im >>> F;
    ovf_mre = !((&sh_re[SW-1:W-1]) || !(|sh_re[SW-1:W-1]));
    ovf_mim = !((&sh_im[SW-1:W-1]) || !(|sh_im[SW-1:W-1]));
    mr_re  = ovf_mre ? (sh_re[SW-1] ? SMIN : SMAX) : sh_re[W-1:0];
    mr_im  = ovf_mim ? (sh_im[SW-1] ? SMIN : SMAX) : sh_im[W-1:0];
    mag_re = div_re[SW-1] ? PW'(-div_re) : PW'(div_re);
    mag_im = div_im[SW-1] ? PW'(-div_im) : PW'(div_im);

    c2.valid  = v1;
    c2.op     = op1;
    c2.neg_re = div_re[SW-1];
    c2.neg_im = div_im[SW-1];
    c2.dz     = (op1 == OP_DIV) && (dval == '0);
    case (op1)
      OP_ADD, OP_SUB: begin
        r2_re = s1_re; r2_im = s1_im; r2_sat = s1_sat;
      end
      OP_MUL: begin
        r2_re = mr_re; r2_im = mr_im; r2_sat = ovf_mre || ovf_mim;
      end
      default: begin
        r2_re = '0; r2_im = '0; r2_sat = 1'b0;
      end
    endcase
  end

  // stage chain, index 0 is the stage 2 register
  ctrl_t          cs      [NS+1];
  logic [RW-1:0]  rem_re  [NS+1];
  logic [RW-1:0]  rem_im  [NS+1];
  logic [W:0]     q_re    [NS+1];
  logic [W:0]     q_im    [NS+1];
  logic [PW-1:0]  dd      [NS+1];
  logic [SW-1:0]  sq_rem  [NS+1];
  logic [W-1:0]   sq_root [NS+1];
  logic [W-1:0]   res_re  [NS+1];
  logic [W-1:0]   res_im  [NS+1];
  logic           res_sat [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cs[0] <= '0;
    end else if (en) begin
      cs[0] <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re[0]  <= RW'(mag_re) << F;
      rem_im[0]  <= RW'(mag_im) << F;
      q_re[0]    <= '0;
      q_im[0]    <= '0;
      dd[0]      <= dval;
      sq_rem[0]  <= SW'(dval);
      sq_root[0] <= '0;
      res_re[0]  <= r2_re;
      res_im[0]  <= r2_im;
      res_sat[0] <= r2_sat;
    end
  end

  // ---------------------------------------------------------------
  // stages 3 .. W+3: restoring divide and square root, msb first;
  // the top quotient bit marks a quotient past the result range
  // ---------------------------------------------------------------
  generate
    for (genvar i = 0; i < NS; i++) begin : g_step
      cau_step #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .K          (W - i)
      ) u_step (
        .clk         (clk),
        .rst         (rst),
        .en          (en),
        .ctrl_in     (cs[i]),
        .rem_re_in   (rem_re[i]),
        .rem_im_in   (rem_im[i]),
        .q_re_in     (q_re[i]),
        .q_im_in     (q_im[i]),
        .d_in        (dd[i]),
        .sq_rem_in   (sq_rem[i]),
        .sq_root_in  (sq_root[i]),
        .res_re_in   (res_re[i]),
        .res_im_in   (res_im[i]),
        .sat_in      (res_sat[i]),
        .ctrl_out    (cs[i+1]),
        .rem_re_out  (rem_re[i+1]),
        .rem_im_out  (rem_im[i+1]),
        .q_re_out    (q_re[i+1]),
        .q_im_out    (q_im[i+1]),
        .d_out       (dd[i+1]),
        .sq_rem_out  (sq_rem[i+1]),
        .sq_root_out (sq_root[i+1]),
        .res_re_out  (res_re[i+1]),
        .res_im_out  (res_im[i+1]),
        .sat_out     (res_sat[i+1])
      );
    end
  endgenerate

  // ---------------------------------------------------------------
  // last stage: sign and saturation of quotient and root, output register
  // ---------------------------------------------------------------
  ctrl_t      cl;
  logic [W:0] ql_re, ql_im;
  logic [W-1:0] root;
  logic [W-1:0] f_re, f_im, dq_re, dq_im;
  logic         f_dz, f_sat, dov_re, dov_im;

  always_comb begin
    cl    = cs[NS];
    ql_re = q_re[NS];
    ql_im = q_im[NS];
    root  = sq_root[NS];

    // positive bound is 2^(W-1)-1, negative bound 2^(W-1)
    if (!cl.neg_re) begin
      dov_re = ql_re[W] || ql_re[W-1];
      dq_re  = dov_re ? SMAX : ql_re[W-1:0];
    end else begin
      dov_re = ql_re[W] || (ql_re[W-1] && (|ql_re[W-2:0]));
      dq_re  = dov_re ? SMIN : (-ql_re[W-1:0]);
    end
    if (!cl.neg_im) begin
      dov_im = ql_im[W] || ql_im[W-1];
      dq_im  = dov_im ? SMAX : ql_im[W-1:0];
    end else begin
      dov_im = ql_im[W] || (ql_im[W-1] && (|ql_im[W-2:0]));
      dq_im  = dov_im ? SMIN : (-ql_im[W-1:0]);
    end

    f_dz = 1'b0;
    case (cl.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        f_re = res_re[NS]; f_im = res_im[NS]; f_sat = res_sat[NS];
      end
      OP_DIV: begin
        if (cl.dz) begin
          f_re = '0; f_im = '0; f_sat = 1'b0; f_dz = 1'b1;
        end else begin
          f_re = dq_re; f_im = dq_im; f_sat = dov_re || dov_im;
        end
      end
      OP_MOD: begin
        f_re  = root[W-1] ? SMAX : root;
        f_im  = '0;
        f_sat = root[W-1];
      end
      default: begin
        f_re = '0; f_im = '0; f_sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_real    <= f_re;
      result_imag    <= f_im;
      divide_by_zero <= f_dz;
      saturated      <= f_sat;
    end
  end

endmodule

FILE: rtl/cau_checker.sv
module cau_checker
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] result_real,
  input logic [DATA_WIDTH-1:0] result_imag,
  input logic                  divide_by_zero,
  input logic                  saturated
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_real) && $stable(result_imag))
    else $error("stalled result changed");

  // a zero divisor gives zero and no clipping
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_real == '0 && result_imag == '0 && !saturated)
    else $error("divide by zero result wrong");

  // a full stalled pipe takes no request
  a_bp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while stalled");

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .result_real    (result_real),
  .result_imag    (result_imag),
  .divide_by_zero (divide_by_zero),
  .saturated      (saturated)
);

FILE: verif/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int DW   = DATA_WIDTH_DEF;
  localparam int FB   = FRAC_BITS_DEF;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 dz;
    logic                 sat;
  } cplx_result_t;

  // one directed request; expected value typed in only when obvious
  typedef struct {
    logic [OP_W-1:0]      op;
    logic signed [DW-1:0] ar, ai, br, bi;
    bit                   typed;
    cplx_result_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] operation = '0;
  logic signed [DW-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] result_real, result_imag;
  logic divide_by_zero, saturated;

  cplx_result_t expected_results[$];
  stim_row_t    stim_table[$];
  int errors = 0;
  int cycles = 0;
  int rx_idle_pct = 0;

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation),
    .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_real(result_real), .result_imag(result_imag),
    .divide_by_zero(divide_by_zero), .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clip to the signed range and note any clipping
  function automatic longint clip16(longint v, inout logic s);
    if (v > SMAX) begin
      s = 1'b1;
      return SMAX;
    end
    if (v < SMIN) begin
      s = 1'b1;
      return SMIN;
    end
    return v;
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // truncating fixed point quotient n / d, d positive
  function automatic longint quot_trunc(longint n, longint d);
    longint q;
    q = ((n < 0 ? -n : n) << FB) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_result_t compute_result(logic [OP_W-1:0] op,
      logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
      logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
    longint xr, xi, yr, yi, re, im, d;
    logic s;
    cplx_result_t r;
    xr = ar; xi = ai; yr = br; yi = bi;
    re = 0; im = 0; s = 1'b0;
    r = '0;
    case (op)
      OP_ADD: begin
        re = xr + yr;
        im = xi + yi;
      end
      OP_SUB: begin
        re = xr - yr;
        im = xi - yi;
      end
      OP_MUL: begin
        // arithmetic shift floors toward minus infinity
        re = (xr * yr - xi * yi) >>> FB;
        im = (xr * yi + xi * yr) >>> FB;
      end
      OP_DIV: begin
        d = yr * yr + yi * yi;
        if (d == 0) begin
          r.dz = 1'b1;
          return r;
        end
        re = quot_trunc(xr * yr + xi * yi, d);
        im = quot_trunc(xi * yr - xr * yi, d);
      end
      OP_MOD: begin
        re = floor_sqrt(xr * xr + xi * xi);
      end
      default: begin
      end
    endcase
    r.re = DW'(clip16(re, s));
    r.im = DW'(clip16(im, s));
    r.sat = s;
    return r;
  endfunction

  function automatic logic signed [DW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return SMIN;
      1: return SMAX;
      2: return '0;
      3: return DW'($urandom_range(0, 1023)) - DW'(512);
      4: return DW'($urandom_range(0, 63)) - DW'(32);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, logic signed [DW-1:0] ar,
      logic signed [DW-1:0] ai, logic signed [DW-1:0] br, logic signed [DW-1:0] bi,
      bit typed, cplx_result_t want);
    stim_row_t row;
    row.op = op; row.ar = ar; row.ai = ai; row.br = br; row.bi = bi;
    row.typed = typed; row.want = want;
    stim_table.push_back(row);
  endtask

  // drive one request, hold it until taken, then log what should come back
  task automatic send_request(logic [OP_W-1:0] op, logic signed [DW-1:0] ar,
      logic signed [DW-1:0] ai, logic signed [DW-1:0] br, logic signed [DW-1:0] bi,
      int tx_idle_pct, bit typed, cplx_result_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    a_real <= ar; a_imag <= ai; b_real <= br; b_imag <= bi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(typed ? want : compute_result(op, ar, ai, br, bi));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int n, int tx_idle_pct, int rx_pct);
    logic [OP_W-1:0] op;
    logic signed [DW-1:0] ar, ai, br, bi;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      // mostly legal opcodes, a few of the unused ones
      op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(5, 7))
                                        : OP_W'($urandom_range(0, 4));
      ar = pick_operand(); ai = pick_operand();
      br = pick_operand(); bi = pick_operand();
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_request(op, ar, ai, br, bi, tx_idle_pct, 1'b0, '0);
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // result checker, samples pre-edge values
  always @(posedge clk) begin
    cplx_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {result_real, result_imag, divide_by_zero, saturated};
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.re !== want.re) begin
          errors++;
          $display("%0t: result_real expected %0d actual %0d", $time, want.re, got.re);
        end
        if (got.im !== want.im) begin
          errors++;
          $display("%0t: result_imag expected %0d actual %0d", $time, want.im, got.im);
        end
        if (got.dz !== want.dz) begin
          errors++;
          $display("%0t: divide_by_zero expected %0b actual %0b", $time, want.dz, got.dz);
        end
        if (got.sat !== want.sat) begin
          errors++;
          $display("%0t: saturated expected %0b actual %0b", $time, want.sat, got.sat);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // directed table: extremes, every opcode, zero divisor, unused codes
    add_row(OP_ADD, SMAX, SMAX, SMAX, SMAX, 1, '{SMAX, SMAX, 1'b0, 1'b1});
    add_row(OP_ADD, SMIN, SMIN, SMIN, SMIN, 1, '{SMIN, SMIN, 1'b0, 1'b1});
    add_row(OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, 1'b0, 1'b0});
    add_row(OP_ADD, 16'sd256, -16'sd512, 16'sd100, 16'sd3, 0, '0);
    add_row(OP_SUB, SMIN, SMIN, SMAX, SMAX, 1, '{SMIN, SMIN, 1'b0, 1'b1});
    add_row(OP_SUB, SMAX, SMAX, SMIN, SMIN, 1, '{SMAX, SMAX, 1'b0, 1'b1});
    add_row(OP_SUB, 16'sd1000, -16'sd7, 16'sd33, 16'sd44, 0, '0);
    add_row(OP_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1, '{16'sd256, 16'sd0, 1'b0, 1'b0});
    add_row(OP_MUL, SMIN, SMIN, SMIN, SMIN, 0, '0);
    add_row(OP_MUL, SMAX, SMIN, SMAX, SMAX, 0, '0);
    add_row(OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0, 1, '{-16'sd1, 16'sd0, 1'b0, 1'b0});
    add_row(OP_MUL, 16'sd300, -16'sd77, -16'sd129, 16'sd5, 0, '0);
    add_row(OP_DIV, SMAX, SMIN, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, 1'b1, 1'b0});
    add_row(OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, 1'b1, 1'b0});
    add_row(OP_DIV, SMAX, SMAX, 16'sd1, 16'sd0, 0, '0);
    add_row(OP_DIV, SMIN, SMIN, SMIN, SMIN, 0, '0);
    add_row(OP_DIV, -16'sd1, 16'sd0, 16'sd3, 16'sd0, 0, '0);
    add_row(OP_DIV, 16'sd512, 16'sd256, -16'sd300, 16'sd9, 0, '0);
    add_row(OP_MOD, SMIN, SMIN, 16'sd0, 16'sd0, 1, '{SMAX, 16'sd0, 1'b0, 1'b1});
    add_row(OP_MOD, 16'sd3, -16'sd4, 16'sd0, 16'sd0, 1, '{16'sd5, 16'sd0, 1'b0, 1'b0});
    add_row(OP_MOD, SMAX, 16'sd0, SMIN, SMAX, 0, '0);
    add_row(OP_W'(5), SMAX, SMIN, SMAX, SMIN, 1, '{16'sd0, 16'sd0, 1'b0, 1'b0});
    add_row(OP_W'(6), 16'sd1, 16'sd2, 16'sd3, 16'sd4, 1, '{16'sd0, 16'sd0, 1'b0, 1'b0});
    add_row(OP_W'(7), -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1, '{16'sd0, 16'sd0, 1'b0, 1'b0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    rx_idle_pct = 20;
    foreach (stim_table[i])
      send_request(stim_table[i].op, stim_table[i].ar, stim_table[i].ai,
                   stim_table[i].br, stim_table[i].bi, 10,
                   stim_table[i].typed, stim_table[i].want);
    // sender holds off until the pipe is empty
    wait_drained();

    random_phase(380, 12, 49);
    random_phase(380, 49, 12);
    random_phase(380, 0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cau_pkg.sv
rtl/cau_step.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
verif/tb_complex_arithmetic_unit.sv
